>>> design/art_pkg.sv
// Shared types and constants for the address region table.
package art_pkg;

  localparam int MAX_REGIONS = 16;
  localparam int IDX_W = $clog2(MAX_REGIONS);
  localparam int CNT_W = $clog2(MAX_REGIONS + 1);
  localparam int VA_W = 48;
  localparam int LEN_W = 49;
  localparam int PA_W = 52;
  localparam int PROT_W = 8;
  localparam int END_W = LEN_W + 1;

  localparam logic [2:0] SEL_VALEN = 3'd1;
  localparam logic [2:0] SEL_PA = 3'd2;
  localparam logic [2:0] SEL_PROT = 3'd4;

  typedef enum logic [2:0] {
    REQ_ADD    = 3'd0,
    REQ_LOOKUP = 3'd1,
    REQ_MATCH  = 3'd2,
    REQ_REMOVE = 3'd3,
    REQ_CHPROT = 3'd4,
    REQ_MOVE   = 3'd5
  } req_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NOTFND  = 3'd1,
    ST_OVERLAP = 3'd2,
    ST_FULL    = 3'd3,
    ST_PINNED  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_SH_RD,
    S_SH_WR,
    S_UPD,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [PROT_W-1:0] prot;
    logic [PA_W-1:0]   pa;
    logic [LEN_W-1:0]  len;
    logic [VA_W-1:0]   va;
  } region_t;

  typedef struct packed {
    logic             re;
    logic [IDX_W-1:0] raddr;
    logic             we;
    logic [IDX_W-1:0] waddr;
    region_t          wdata;
  } mem_req_t;

  typedef struct packed {
    logic             busy;
    logic [CNT_W-1:0] count;
  } ctrl_stat_t;

endpackage

>>> design/art_region_mem.sv
// Region entry memory, one write and one registered read port.
module art_region_mem
  import art_pkg::*;
(
  input  logic     clk,
  input  mem_req_t req,
  output region_t  rdata
);

  region_t mem [MAX_REGIONS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

>>> design/art_ctrl.sv
// Request sequencer: walks the table, applies updates, holds the result item.
module art_ctrl
  import art_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [PROT_W-1:0] pin_mask,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_req,
  input  region_t           in_region,
  input  logic [2:0]        in_mask,
  input  logic [PROT_W-1:0] in_nprot,
  input  logic [PA_W-1:0]   in_npa,
  output logic              out_valid,
  input  logic              out_ready,
  output status_t           out_status,
  output region_t           out_region,
  output mem_req_t          mreq,
  input  region_t           rdata,
  output ctrl_stat_t        stat
);

  state_t state, state_next;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] idx;
  logic [2:0] req;
  region_t r;
  logic [2:0] mask;
  logic [PROT_W-1:0] nprot;
  logic [PA_W-1:0] npa;
  status_t res_st;
  region_t res;

  logic [END_W-1:0] r_end, e_end;
  logic ovl, lk_hit, m_hit, hit, pinned, out_free, more_shift_chk, more_shift_wr;
  logic [2:0] sel;

  assign r_end = {2'b0, r.va} + {1'b0, r.len} - END_W'(1);
  assign e_end = {2'b0, rdata.va} + {1'b0, rdata.len} - END_W'(1);
  assign ovl = !((r_end < {2'b0, rdata.va}) || ({2'b0, r.va} > e_end));
  assign lk_hit = (r.va >= rdata.va) && ({2'b0, r.va} <= e_end);
  assign pinned = |(rdata.prot & pin_mask);
  assign out_free = !out_valid || out_ready;
  assign more_shift_chk = ({1'b0, idx} + CNT_W'(1)) < count;
  assign more_shift_wr = ({1'b0, idx} + CNT_W'(2)) < count;

  always_comb begin
    unique case (req)
      REQ_MATCH:  sel = mask;
      REQ_CHPROT: sel = SEL_VALEN | SEL_PA;
      default:    sel = SEL_VALEN | SEL_PROT;
    endcase
  end

  assign m_hit = (!(|(sel & SEL_VALEN)) || (rdata.va == r.va && rdata.len == r.len)) &&
                 (!(|(sel & SEL_PA)) || rdata.pa == r.pa) &&
                 (!(|(sel & SEL_PROT)) || rdata.prot == r.prot);
  assign hit = (req == REQ_ADD) ? ovl : (req == REQ_LOOKUP) ? lk_hit : m_hit;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_req > REQ_MOVE) begin
            state_next = S_DONE;
          end else if (in_req == REQ_ADD && in_region.len == '0) begin
            state_next = S_DONE;
          end else if (count == '0) begin
            state_next = (in_req == REQ_ADD) ? S_UPD : S_DONE;
          end else begin
            state_next = S_READ;
          end
        end
      end
      S_READ: state_next = S_CHECK;
      S_CHECK: begin
        if (hit) begin
          unique case (req)
            REQ_CHPROT: state_next = S_UPD;
            REQ_MOVE:   state_next = pinned ? S_DONE : S_UPD;
            REQ_REMOVE: state_next = (!pinned && more_shift_chk) ? S_SH_RD : S_DONE;
            default:    state_next = S_DONE;
          endcase
        end else if (idx == '0) begin
          state_next = (req == REQ_ADD && count != CNT_W'(MAX_REGIONS)) ? S_UPD : S_DONE;
        end else begin
          state_next = S_READ;
        end
      end
      S_SH_RD: state_next = S_SH_WR;
      S_SH_WR: state_next = more_shift_wr ? S_SH_RD : S_DONE;
      S_UPD:   state_next = S_DONE;
      S_DONE:  state_next = out_free ? S_IDLE : S_DONE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    mreq = '0;
    in_ready = (state == S_IDLE);
    unique case (state)
      S_READ: begin
        mreq.re = 1'b1;
        mreq.raddr = idx;
      end
      S_SH_RD: begin
        mreq.re = 1'b1;
        mreq.raddr = idx + IDX_W'(1);
      end
      S_SH_WR: begin
        mreq.we = 1'b1;
        mreq.waddr = idx;
        mreq.wdata = rdata;
      end
      S_UPD: begin
        mreq.we = 1'b1;
        mreq.waddr = idx;
        mreq.wdata = res;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            req <= in_req;
            r <= in_region;
            mask <= in_mask;
            nprot <= in_nprot;
            npa <= in_npa;
            if (in_req == REQ_ADD && in_region.len == '0) begin
              idx <= IDX_W'(count - CNT_W'(1));
              res <= '0;
              res_st <= ST_OVERLAP;
            end else if (in_req == REQ_ADD && count == '0) begin
              idx <= '0;
              res <= in_region;
              res_st <= ST_OK;
            end else begin
              idx <= IDX_W'(count - CNT_W'(1));
              res <= '0;
              res_st <= ST_NOTFND;
            end
          end
        end
        S_CHECK: begin
          if (hit) begin
            if (req == REQ_ADD) begin
              res <= '0;
              res_st <= ST_OVERLAP;
            end else begin
              res_st <= (pinned && (req == REQ_REMOVE || req == REQ_MOVE)) ? ST_PINNED : ST_OK;
              unique case (req)
                REQ_CHPROT: res <= {nprot, rdata.pa, rdata.len, rdata.va};
                REQ_MOVE:   res <= pinned ? rdata : {rdata.prot, npa, rdata.len, rdata.va};
                REQ_REMOVE: begin
                  res <= rdata;
                  if (!pinned && !more_shift_chk) count <= count - CNT_W'(1);
                end
                default: res <= rdata;
              endcase
            end
          end else if (idx == '0) begin
            if (req == REQ_ADD) begin
              if (count == CNT_W'(MAX_REGIONS)) begin
                res_st <= ST_FULL;
              end else begin
                res <= r;
                res_st <= ST_OK;
                idx <= IDX_W'(count);
              end
            end
          end else begin
            idx <= idx - IDX_W'(1);
          end
        end
        S_SH_WR: begin
          idx <= idx + IDX_W'(1);
          if (!more_shift_wr) count <= count - CNT_W'(1);
        end
        S_UPD: begin
          if (req == REQ_ADD) count <= count + CNT_W'(1);
        end
        S_DONE: begin
          if (out_free) begin
            out_status <= res_st;
            out_region <= res;
          end
        end
        default: ;
      endcase
    end
  end

  assign stat.busy = (state != S_IDLE);
  assign stat.count = count;

endmodule

>>> design/address_region_table.sv
// Top level of the address region table.
//
//  channel  | dir | handshake                  | content
//  cfg      | in  | cfg_wen                    | cfg_wdata: pin flag mask
//  s_axis   | in  | s_axis_tvalid/tready       | tuser: request type; tdata: region, mask, updates
//  m_axis   | out | m_axis_tvalid/tready       | tuser: status; tdata: region
//
// An item visits table entries newest first (memory read, then compare),
// between accept and result; a successful add, change protection or unpinned
// move adds a write back, and remove adds a read and a write for each entry
// moved down. Every entry lives in one memory with one read port.
// Reset clears the entry count and the result valid; no clearing pass.
// The result register frees the engine; a stalled result holds the next item.
module address_region_table
  import art_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_wen,
  input  logic [7:0]    cfg_wdata,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // region start, region length, physical start, flags, match mask, new flags,
  // new physical start, pad
  input  logic [223:0]  s_axis_tdata,
  // req_type
  input  logic [2:0]    s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // hit_va, hit_len, hit_pa, hit_prot, pad
  output logic [159:0]  m_axis_tdata,
  // status
  output logic [2:0]    m_axis_tuser
);

  logic [PROT_W-1:0] pin_mask;
  mem_req_t mreq;
  region_t rdata, out_region;
  status_t out_status;
  ctrl_stat_t stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      pin_mask <= 8'd128;
    end else if (cfg_wen) begin
      pin_mask <= cfg_wdata;
    end
  end

  art_region_mem u_mem (
    .clk   (clk),
    .req   (mreq),
    .rdata (rdata)
  );

  art_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .pin_mask   (pin_mask),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_req     (s_axis_tuser),
    .in_region  (s_axis_tdata[156:0]),
    .in_mask    (s_axis_tdata[159:157]),
    .in_nprot   (s_axis_tdata[167:160]),
    .in_npa     (s_axis_tdata[219:168]),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_status (out_status),
    .out_region (out_region),
    .mreq       (mreq),
    .rdata      (rdata),
    .stat       (stat)
  );

  assign m_axis_tdata = {3'b0, out_region};
  assign m_axis_tuser = out_status;

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    stat.count <= CNT_W'(MAX_REGIONS)) else $error("entry count above table size");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> stat.busy) else $error("accepted item not in work");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && stat.count != $past(stat.count) |->
      (stat.count == $past(stat.count) + CNT_W'(1) ||
       stat.count == $past(stat.count) - CNT_W'(1))) else $error("entry count jumped");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    !stat.busy |-> !mreq.we) else $error("table write while idle");

endmodule
